// ===== src/tslac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tilt-sensed lift actuator control.
// No dependencies; used by tslac_angle and the top level.
package tslac_pkg;

    // motion modes
    localparam logic [1:0] MODE_UP      = 2'd0;
    localparam logic [1:0] MODE_DOWN    = 2'd1;
    localparam logic [1:0] MODE_RISING  = 2'd2;
    localparam logic [1:0] MODE_FALLING = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWERED  = 2'd0;
    localparam logic [1:0] CFG_RAISED   = 2'd1;
    localparam logic [1:0] CFG_LENGTH   = 2'd2;

    // angle accumulator, 1/256 centidegree units
    localparam int          ACC_W     = 25;
    localparam logic [24:0] ACC_90    = 25'd2304000;
    localparam logic [14:0] ANGLE_MAX = 15'd18000;

    // duty shaping
    localparam logic [7:0]  DUTY_FULL = 8'd128;
    localparam logic [7:0]  DUTY_MIN  = 8'd78;
    localparam logic [14:0] DUTY_RAMP = 15'd700;
    localparam logic [12:0] RECIP_14  = 13'd4682;   // ceil(65536/14)

    typedef struct packed {
        logic        packet_ready;
        logic [7:0]  packet_length;
        logic        button_raise;
        logic        button_lower;
        logic        button_aux;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  motor_duty;
        logic        drive_forward;
        logic        drive_backward;
        logic        busy_lamp;
        logic        idle_lamp;
        logic [14:0] tilt_angle;
        logic [1:0]  motion_mode;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic ack;
    } t_ang_ctl;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic [20:0] atan_entry(input logic [4:0] idx);
        logic [20:0] v;
        unique case (idx)
            5'd0:  v = 21'd1152000;
            5'd1:  v = 21'd680065;
            5'd2:  v = 21'd359328;
            5'd3:  v = 21'd182400;
            5'd4:  v = 21'd91554;
            5'd5:  v = 21'd45822;
            5'd6:  v = 21'd22916;
            5'd7:  v = 21'd11459;
            5'd8:  v = 21'd5730;
            5'd9:  v = 21'd2865;
            5'd10: v = 21'd1432;
            5'd11: v = 21'd716;
            5'd12: v = 21'd358;
            5'd13: v = 21'd179;
            5'd14: v = 21'd90;
            5'd15: v = 21'd45;
            5'd16: v = 21'd22;
            5'd17: v = 21'd11;
            5'd18: v = 21'd6;
            5'd19: v = 21'd3;
            5'd20: v = 21'd1;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/tslac_angle.sv =====
`timescale 1ns / 1ps
// Iterative tilt angle unit: squares, bit-serial square root, CORDIC vectoring.
// Depends on tslac_pkg.
module tslac_angle #(
    parameter int ACCEL_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tslac_pkg::t_ang_ctl i_ctl,
    input  logic [15:0]         i_ax,
    input  logic [15:0]         i_ay,
    input  logic [15:0]         i_az,
    output logic                o_done,
    output logic [14:0]         o_angle
);
    localparam int A   = ACCEL_WIDTH;
    localparam int NW  = 2 * A;
    localparam int CDW = A + 10;
    localparam int CNW = $clog2((A > CORDIC_STEPS) ? A : CORDIC_STEPS);
    localparam int AW  = tslac_pkg::ACC_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQZ  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_CSET = 3'd4;
    localparam logic [2:0] ST_CORD = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [CNW-1:0]        r_cnt, n_cnt;
    logic signed [A-1:0]   r_ax, r_ay, r_az, n_ax, n_ay, n_az;
    logic                  r_zero, n_zero;
    logic [NW-1:0]         r_sum, n_sum, r_root, n_root, r_bit, n_bit;
    logic signed [CDW-1:0] r_cx, r_cy, n_cx, n_cy;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic [14:0]           r_angle, n_angle;

    logic signed [A-1:0]   ext_x, ext_y, ext_z, mul_op;
    logic signed [NW-1:0]  mul_ext, sq;
    logic [NW-1:0]         trial;
    logic signed [CDW-1:0] dx, dy;
    logic signed [AW-1:0]  tab, acc_pos, rnd;

    // take the low A bits as two's complement
    always_comb begin
        for (int k = 0; k < A; k++) begin
            ext_x[k] = (k < 16) ? i_ax[k & 15] : 1'b0;
            ext_y[k] = (k < 16) ? i_ay[k & 15] : 1'b0;
            ext_z[k] = (k < 16) ? i_az[k & 15] : 1'b0;
        end
    end

    // shared squarer
    assign mul_op  = (r_state == ST_SQX) ? r_ax : r_az;
    assign mul_ext = NW'(mul_op);
    assign sq      = mul_ext * mul_ext;

    // shared shift/add terms
    assign trial = r_root + r_bit;
    assign dx    = r_cy >>> r_cnt;
    assign dy    = r_cx >>> r_cnt;
    assign tab   = $signed(AW'(tslac_pkg::atan_entry(5'(r_cnt))));
    assign acc_pos = r_acc[AW-1] ? '0 : r_acc;
    assign rnd     = (acc_pos + AW'(128)) >>> 8;

    // sequencer and datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_az    = r_az;
        n_zero  = r_zero;
        n_sum   = r_sum;
        n_root  = r_root;
        n_bit   = r_bit;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_acc   = r_acc;
        n_angle = r_angle;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_ax    = ext_x;
                    n_ay    = ext_y;
                    n_az    = ext_z;
                    n_zero  = (ext_x == '0) && (ext_y == '0) && (ext_z == '0);
                    n_state = ST_SQX;
                end
            end
            ST_SQX: begin
                n_sum   = sq;
                n_state = ST_SQZ;
            end
            ST_SQZ: begin
                n_sum   = r_sum + sq;
                n_root  = '0;
                n_bit   = NW'(1) << (NW - 2);
                n_cnt   = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_sum >= trial) begin
                    n_sum  = r_sum - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(A - 1)) begin
                    n_state = ST_CSET;
                end
            end
            ST_CSET: begin
                // negative y: pre-rotate by 90 degrees
                if (r_ay[A-1]) begin
                    n_cx  = $signed(CDW'({r_root[A-1:0], 8'd0}));
                    n_cy  = -(CDW'(r_ay)) <<< 8;
                    n_acc = $signed(tslac_pkg::ACC_90);
                end else begin
                    n_cx  = CDW'(r_ay) <<< 8;
                    n_cy  = $signed(CDW'({r_root[A-1:0], 8'd0}));
                    n_acc = '0;
                end
                n_cnt   = '0;
                n_state = ST_CORD;
            end
            ST_CORD: begin
                if (!r_cy[CDW-1]) begin
                    n_cx  = r_cx + dx;
                    n_cy  = r_cy - dy;
                    n_acc = r_acc + tab;
                end else begin
                    n_cx  = r_cx - dx;
                    n_cy  = r_cy + dy;
                    n_acc = r_acc - tab;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(CORDIC_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_zero) begin
                    n_angle = '0;
                end else if (rnd > $signed(AW'(tslac_pkg::ANGLE_MAX))) begin
                    n_angle = tslac_pkg::ANGLE_MAX;
                end else begin
                    n_angle = rnd[14:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ctl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_az    <= n_az;
        r_zero  <= n_zero;
        r_sum   <= n_sum;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_acc   <= n_acc;
        r_angle <= n_angle;
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_angle = r_angle;

    // checks
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle <= tslac_pkg::ANGLE_MAX))
        else $error("angle out of range");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_ctl.ack |=> o_done && $stable(o_angle))
        else $error("result dropped before ack");
    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CSET) |-> (r_bit == '0))
        else $error("square root not finished");
endmodule

// ===== src/tilt_sensed_lift_actuator_control.sv =====
`timescale 1ns / 1ps
// Lift actuator control: command handling, motion and duty, output register.
// Depends on tslac_pkg and tslac_angle.
// The result word is registered once the angle unit has squared x and z, extracted the square
// root bit by bit, set up the CORDIC vector, run the CORDIC steps and rounded the angle.
// A new word is accepted only after the previous result enters the output register; stalls delay it.
// Reset (synchronous, active low): mode down, goal down, limits 9000/13500, length 4.
module tilt_sensed_lift_actuator_control #(
    parameter int ACCEL_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tslac_pkg::t_in_word  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tslac_pkg::t_out_word o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [14:0]          i_cfg_data
);
    logic [14:0] r_lowered, r_raised;
    logic [7:0]  r_exp_len;
    logic [1:0]  r_mode, n_mode;
    logic        r_goal_up, n_goal_up;
    logic        r_busy;
    logic        r_out_valid;
    tslac_pkg::t_out_word r_out, n_out;

    tslac_pkg::t_ang_ctl ang_ctl;
    logic        ang_done;
    logic [14:0] ang;
    logic        in_acc, fin, cur_idle, acc_idle;
    logic [14:0] lim_a, lim_b, da, db, near_d;
    logic [22:0] ramp;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign fin         = ang_done && (!r_out_valid || i_out_ready);
    assign ang_ctl.start = in_acc;
    assign ang_ctl.ack   = fin;

    tslac_angle #(
        .ACCEL_WIDTH (ACCEL_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_angle (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ang_ctl),
        .i_ax   (i_in.accel_x),
        .i_ay   (i_in.accel_y),
        .i_az   (i_in.accel_z),
        .o_done (ang_done),
        .o_angle(ang)
    );

    // remote command: only taken while idle
    assign acc_idle = r_goal_up ? (r_mode == tslac_pkg::MODE_UP)
                                : (r_mode == tslac_pkg::MODE_DOWN);
    always_comb begin
        n_goal_up = r_goal_up;
        if (in_acc && i_in.packet_ready && (i_in.packet_length == r_exp_len) && acc_idle) begin
            priority if (i_in.button_raise) n_goal_up = 1'b1;
            else if (i_in.button_lower)     n_goal_up = 1'b0;
            else if (i_in.button_aux)       n_goal_up = 1'b1;
            else                            n_goal_up = r_goal_up;
        end
    end

    // distance to the nearer limit, then duty ramp (d/14 by reciprocal)
    assign cur_idle = acc_idle;
    assign lim_a  = r_goal_up ? r_lowered : r_raised;
    assign lim_b  = r_goal_up ? r_raised  : r_lowered;
    assign da     = (ang > lim_a) ? (ang - lim_a) : (lim_a - ang);
    assign db     = (ang > lim_b) ? (ang - lim_b) : (lim_b - ang);
    assign near_d = (da < db) ? da : db;
    assign ramp   = 23'(near_d[9:0]) * 23'(tslac_pkg::RECIP_14);

    // motion step
    always_comb begin
        n_mode                 = r_mode;
        n_out.motor_duty       = '0;
        n_out.drive_forward    = 1'b0;
        n_out.drive_backward   = 1'b0;
        n_out.busy_lamp        = !cur_idle;
        n_out.idle_lamp        = cur_idle;
        n_out.tilt_angle       = ang;
        if (!cur_idle) begin
            n_out.motor_duty = (near_d > tslac_pkg::DUTY_RAMP) ? tslac_pkg::DUTY_FULL
                             : tslac_pkg::DUTY_MIN + 8'(ramp[22:16]);
            if (r_goal_up) begin
                n_out.drive_forward = 1'b1;
                n_mode = (ang > r_raised) ? tslac_pkg::MODE_UP : tslac_pkg::MODE_RISING;
            end else begin
                n_out.drive_backward = 1'b1;
                n_mode = (ang < r_lowered) ? tslac_pkg::MODE_DOWN : tslac_pkg::MODE_FALLING;
            end
        end
        n_out.motion_mode = n_mode;
    end

    // control state, configuration, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowered   <= 15'd9000;
            r_raised    <= 15'd13500;
            r_exp_len   <= 8'd4;
            r_mode      <= tslac_pkg::MODE_DOWN;
            r_goal_up   <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tslac_pkg::CFG_LOWERED: r_lowered <= i_cfg_data;
                    tslac_pkg::CFG_RAISED:  r_raised  <= i_cfg_data;
                    tslac_pkg::CFG_LENGTH:  r_exp_len <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_goal_up <= n_goal_up;
            if (in_acc) begin
                r_busy <= 1'b1;
            end
            if (fin) begin
                r_mode      <= n_mode;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fin) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted word not tracked");
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.drive_forward && r_out.drive_backward))
        else $error("both directions driven");
    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.motor_duty == 8'd0) == r_out.idle_lamp))
        else $error("duty disagrees with idle lamp");
endmodule
